>>> rtl/rcavg_pkg.sv
// ----------------------------------------------------------------------------
// rcavg_pkg
// Shared types, constants and the channel mapping table for the radio-control
// channel averaging and remapping core.
// ----------------------------------------------------------------------------
package rcavg_pkg;

    // field widths
    localparam int PULSE_W   = 16;
    localparam int CTL_W     = 8;
    localparam int NUM_IN    = 7;
    localparam int NUM_CTL   = 7;
    localparam int CTL_IDX_W = 3;
    localparam int ROW_W     = 4;
    localparam int SLEW_W    = 8;
    localparam int MAP_W     = 4;
    localparam int NUM_ROWS  = 14;

    // reset values and scaling constants
    localparam int RESET_SAMPLE = 625;
    localparam int SCALE_MUL    = 13;
    localparam int ROUND_ADD    = 32768;
    localparam int ROUND_SHIFT  = 16;
    localparam logic [CTL_W-1:0] CTL_MAX = 8'hFF;
    localparam logic [CTL_W-1:0] NEUTRAL = 8'd128;

    // register index, taken from paddr[2]
    localparam logic [0:0] REG_TXRX_ROW   = 1'b0;
    localparam logic [0:0] REG_SLEW_LIMIT = 1'b1;

    // configuration seen by the back end
    typedef struct packed {
        logic [ROW_W-1:0]  txrx_row;
        logic [SLEW_W-1:0] slew_limit;
    } cfg_t;

    // receiver channel feeding each control, one row per radio type
    localparam logic [MAP_W-1:0] CHAN_MAP [NUM_ROWS][NUM_CTL] = '{
        '{4'd2, 4'd0, 4'd1, 4'd3, 4'd4, 4'd5, 4'd6},
        '{4'd1, 4'd0, 4'd3, 4'd2, 4'd4, 4'd5, 4'd6},
        '{4'd4, 4'd2, 4'd1, 4'd0, 4'd5, 4'd3, 4'd6},
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6},
        '{4'd6, 4'd0, 4'd3, 4'd5, 4'd2, 4'd4, 4'd1},
        '{4'd5, 4'd0, 4'd3, 4'd6, 4'd2, 4'd1, 4'd4},
        '{4'd5, 4'd0, 4'd3, 4'd6, 4'd2, 4'd1, 4'd4},
        '{4'd4, 4'd0, 4'd3, 4'd5, 4'd2, 4'd1, 4'd6},
        '{4'd2, 4'd0, 4'd1, 4'd3, 4'd4, 4'd6, 4'd5},
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6},
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6},
        '{4'd4, 4'd0, 4'd2, 4'd3, 4'd1, 4'd5, 4'd6},
        '{4'd2, 4'd0, 4'd1, 4'd3, 4'd4, 4'd5, 4'd6},
        '{4'd2, 4'd0, 4'd1, 4'd3, 4'd4, 4'd5, 4'd6}
    };

    // source channel for a control; rows past the table use the custom row
    function automatic logic [MAP_W-1:0] map_src(input logic [ROW_W-1:0] row,
                                                 input logic [CTL_IDX_W-1:0] k);
        logic [ROW_W-1:0] r;
        r = (row < ROW_W'(NUM_ROWS)) ? row : ROW_W'(NUM_ROWS - 1);
        return CHAN_MAP[r][k];
    endfunction

endpackage

>>> rtl/rcavg_front.sv
// ----------------------------------------------------------------------------
// rcavg_front
// Accepts a frame of pulse widths, updates the per-channel sample history and
// running sums, and queues the new sums for the back end.
// ----------------------------------------------------------------------------
module rcavg_front #(
    parameter int CHANNELS  = 7,
    parameter int AVG_DEPTH = 4,
    parameter int SUM_W     = 18
) (
    input  logic                                           aclk,
    input  logic                                           aresetn,
    input  logic                                           s_tvalid,
    output logic                                           s_tready,
    input  logic [rcavg_pkg::NUM_IN-1:0][rcavg_pkg::PULSE_W-1:0] pulse,
    input  logic                                           q_full,
    output logic                                           q_push,
    output logic [CHANNELS-1:0][SUM_W-1:0]                 q_sums
);
    import rcavg_pkg::*;

    localparam int HEAD_W = $clog2(AVG_DEPTH);
    localparam logic [SUM_W-1:0] RESET_SUM = SUM_W'(RESET_SAMPLE * AVG_DEPTH);

    logic [PULSE_W-1:0]             hist_reg [AVG_DEPTH][CHANNELS];
    logic [CHANNELS-1:0][SUM_W-1:0] sum_reg;
    logic [CHANNELS-1:0][SUM_W-1:0] sum_next;
    logic [CHANNELS-1:0][PULSE_W-1:0] sample;
    logic [HEAD_W-1:0]              head_reg;
    logic                           filled_reg;
    logic                           accept;
    logic                           head_wrap;

    // channels beyond the input fields sample zero
    for (genvar c = 0; c < CHANNELS; c++) begin : g_sample
        if (c < NUM_IN) begin : g_in
            assign sample[c] = pulse[c];
        end else begin : g_zero
            assign sample[c] = '0;
        end
    end

    // drop the oldest sample, add the new one; unwritten slots read as reset
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            sum_next[c] = sum_reg[c]
                        - (filled_reg ? SUM_W'(hist_reg[head_reg][c]) : SUM_W'(RESET_SAMPLE))
                        + SUM_W'(sample[c]);
        end
    end

    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;
    assign head_wrap = (head_reg == HEAD_W'(AVG_DEPTH - 1));
    assign q_push    = accept;
    assign q_sums    = sum_next;

    // control state and running sums
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg   <= '0;
            filled_reg <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                sum_reg[c] <= RESET_SUM;
            end
        end else if (accept) begin
            sum_reg  <= sum_next;
            head_reg <= head_wrap ? '0 : head_reg + HEAD_W'(1);
            if (head_wrap) begin
                filled_reg <= 1'b1;
            end
        end
    end

    // sample history, one slot per frame
    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int c = 0; c < CHANNELS; c++) begin
                hist_reg[head_reg][c] <= sample[c];
            end
        end
    end

endmodule

>>> rtl/rcavg_fifo.sv
// ----------------------------------------------------------------------------
// rcavg_fifo
// Short queue of channel sums between the front end and the back end.
// ----------------------------------------------------------------------------
module rcavg_fifo #(
    parameter int WIDTH = 126,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] head_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign valid     = (count_reg != '0);
    assign head_data = slot_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // queue never overruns or underruns
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("word pushed into a full queue");

    a_no_underrun: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> valid)
        else $error("word popped from an empty queue");

endmodule

>>> rtl/rcavg_back.sv
// ----------------------------------------------------------------------------
// rcavg_back
// Scales the remapped channel sums one control per cycle through a shared
// multiplier, saturates them, slew-limits the throttle and holds the result.
// ----------------------------------------------------------------------------
module rcavg_back #(
    parameter int CHANNELS   = 7,
    parameter int SUM_W      = 18,
    parameter int FULL_SCALE = 255
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  rcavg_pkg::cfg_t                              cfg,
    input  logic                                         q_valid,
    input  logic [CHANNELS-1:0][SUM_W-1:0]               q_sums,
    output logic                                         q_pop,
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    output logic [rcavg_pkg::NUM_CTL*rcavg_pkg::CTL_W-1:0] m_tdata
);
    import rcavg_pkg::*;

    localparam int SCALE_K = FULL_SCALE * SCALE_MUL;
    localparam int SCALE_W = $clog2(SCALE_K + 1);
    localparam int PROD_W  = SUM_W + SCALE_W;
    localparam int RND_W   = PROD_W + 1;

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

    state_t                          state_reg;
    logic [CTL_IDX_W-1:0]            k_reg;
    logic [CTL_IDX_W-1:0]            idx_reg;
    logic                            mv_reg;
    logic [PROD_W-1:0]               prod_reg;
    logic [CTL_W-1:0]                ctl_reg [NUM_CTL];
    logic                            m_tvalid_reg;
    logic [NUM_CTL-1:0][CTL_W-1:0]   m_tdata_reg;
    logic [CTL_W-1:0]                last_thr_reg;

    logic [MAP_W-1:0]                src;
    logic [SUM_W-1:0]                sel_sum;
    logic [PROD_W-1:0]               prod_next;
    logic [RND_W-1:0]                rnd;
    logic [RND_W-1:0]                shifted;
    logic [CTL_W-1:0]                sat_val;
    logic [NUM_CTL-1:0][CTL_W-1:0]   ctl_now;
    logic [NUM_CTL-1:0][CTL_W-1:0]   out_vec;
    logic [CTL_W-1:0]                lim;
    logic [CTL_W-1:0]                lo;
    logic [CTL_W:0]                  hi;
    logic [CTL_W-1:0]                thr;
    logic                            issue;
    logic                            last_k;
    logic                            out_free;
    logic                            emit;

    // pick the mapped channel sum; unmapped controls see zero
    always_comb begin
        src     = map_src(cfg.txrx_row, k_reg);
        sel_sum = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            if (src == MAP_W'(c)) begin
                sel_sum = q_sums[c];
            end
        end
        prod_next = PROD_W'(sel_sum) * PROD_W'(SCALE_K);
    end

    // round, shift and saturate the registered product
    always_comb begin
        rnd     = RND_W'(prod_reg) + RND_W'(ROUND_ADD);
        shifted = rnd >> ROUND_SHIFT;
        sat_val = (shifted > RND_W'(CTL_MAX)) ? CTL_MAX : shifted[CTL_W-1:0];
    end

    // controls as of this cycle, with the product still in flight
    always_comb begin
        for (int i = 0; i < NUM_CTL; i++) begin
            ctl_now[i] = (mv_reg && idx_reg == CTL_IDX_W'(i)) ? sat_val : ctl_reg[i];
        end
    end

    // throttle slew limit against the previous output
    always_comb begin
        lim = cfg.slew_limit;
        lo  = (last_thr_reg > lim) ? last_thr_reg - lim : '0;
        hi  = {1'b0, last_thr_reg} + {1'b0, lim};
        thr = ctl_now[0];
        if (lim != '0) begin
            if (ctl_now[0] < lo) begin
                thr = lo;
            end else if ({1'b0, ctl_now[0]} > hi) begin
                thr = hi[CTL_W-1:0];
            end
        end
        out_vec    = ctl_now;
        out_vec[0] = thr;
    end

    assign issue    = (state_reg == ST_RUN);
    assign last_k   = (k_reg == CTL_IDX_W'(NUM_CTL - 1));
    assign q_pop    = issue && last_k;
    assign out_free = !m_tvalid_reg || m_tready;
    assign emit     = (state_reg == ST_DONE) && out_free;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // sequencer, multiply stage and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            k_reg        <= '0;
            mv_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
            last_thr_reg <= NEUTRAL;
        end else begin
            mv_reg <= issue;
            if (issue) begin
                prod_reg <= prod_next;
                idx_reg  <= k_reg;
            end
            if (mv_reg) begin
                ctl_reg[idx_reg] <= sat_val;
            end
            if (emit) begin
                m_tdata_reg  <= out_vec;
                m_tvalid_reg <= 1'b1;
                last_thr_reg <= thr;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        state_reg <= ST_RUN;
                        k_reg     <= '0;
                    end
                end
                ST_RUN: begin
                    if (last_k) begin
                        state_reg <= ST_DONE;
                    end else begin
                        k_reg <= k_reg + CTL_IDX_W'(1);
                    end
                end
                ST_DONE: begin
                    if (emit) begin
                        k_reg     <= '0;
                        state_reg <= q_valid ? ST_RUN : ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // the frame being scaled stays at the queue head until its last control
    a_run_has_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> q_valid)
        else $error("scaling without a queued frame");

    a_pop_to_done: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> (state_reg == ST_DONE))
        else $error("frame popped without finishing");

    a_last_thr: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> (last_thr_reg == m_tdata_reg[0]))
        else $error("stored throttle differs from sent throttle");

endmodule

>>> rtl/rc_channel_average_remap_core.sv
// ----------------------------------------------------------------------------
// rc_channel_average_remap_core
// Four-frame moving average of seven receiver pulse widths, remapped into the
// internal control order, scaled to bytes and throttle slew-limited.
//
//   channel   direction  word
//   s_        in         seven 16-bit pulse widths, one frame
//   m_        out        seven 8-bit controls, one per frame
//   apb       in/out     txrx_row at 0x0, slew_limit at 0x4
//
// The front end takes a frame whenever the two-entry queue has room. The
// back end scales one control per cycle on a single multiplier. Reset is
// synchronous and clears the sums, the queue and the output valid; history
// slots read as the reset sample until rewritten. A stalled output holds
// the back end; the front end keeps accepting until the queue is full.
// ----------------------------------------------------------------------------
module rc_channel_average_remap_core #(
    parameter int CHANNELS   = 7,
    parameter int AVG_DEPTH  = 4,
    parameter int FULL_SCALE = 255
) (
    input  logic        aclk,
    input  logic        aresetn,
    // pulse_ch0 .. pulse_ch6, 16 bits each, pulse_ch0 lowest
    input  logic [111:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // ctl_throttle, ctl_aileron, ctl_elevator, ctl_rudder, ctl_gear,
    // ctl_aux1, ctl_aux2, 8 bits each, ctl_throttle lowest
    output logic [55:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rcavg_pkg::*;

    localparam int SUM_W = PULSE_W + $clog2(AVG_DEPTH);

    logic [ROW_W-1:0]               row_reg;
    logic [SLEW_W-1:0]              slew_reg;
    cfg_t                           cfg;
    logic                           cfg_wr;
    logic                           q_full;
    logic                           q_push;
    logic                           q_pop;
    logic                           q_valid;
    logic [CHANNELS-1:0][SUM_W-1:0] q_in;
    logic [CHANNELS-1:0][SUM_W-1:0] q_head;

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg  <= '0;
            slew_reg <= '0;
        end else if (cfg_wr) begin
            case (paddr[2:2])
                REG_TXRX_ROW:   row_reg  <= pwdata[ROW_W-1:0];
                REG_SLEW_LIMIT: slew_reg <= pwdata[SLEW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        case (paddr[2:2])
            REG_TXRX_ROW:   prdata = 32'(row_reg);
            REG_SLEW_LIMIT: prdata = 32'(slew_reg);
            default:        prdata = '0;
        endcase
    end

    assign cfg.txrx_row   = row_reg;
    assign cfg.slew_limit = slew_reg;

    // history and sums
    rcavg_front #(
        .CHANNELS  (CHANNELS),
        .AVG_DEPTH (AVG_DEPTH),
        .SUM_W     (SUM_W)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .pulse    (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_sums   (q_in)
    );

    // sums queue
    rcavg_fifo #(
        .WIDTH (CHANNELS * SUM_W),
        .DEPTH (2)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head_data (q_head)
    );

    // scaling, slew limit and output
    rcavg_back #(
        .CHANNELS   (CHANNELS),
        .SUM_W      (SUM_W),
        .FULL_SCALE (FULL_SCALE)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .q_sums   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
